// ===== src/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

   localparam int MAX_SPHERES_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;

   localparam logic [30:0] VIEW_FACTOR_RST = 31'd17560;
   localparam logic [3:0]  MAX_BOUNCES_RST = 4'd5;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TRACE = 1'b1;

   localparam logic [3:0] ATTR_CX   = 4'd0;
   localparam logic [3:0] ATTR_RAD  = 4'd3;
   localparam logic [3:0] ATTR_SR   = 4'd4;
   localparam logic [3:0] ATTR_ER   = 4'd7;
   localparam logic [3:0] ATTR_LAST = 4'd9;

   localparam logic [2:0] CSR_VIEW    = 3'd0;
   localparam logic [2:0] CSR_CAM_X   = 3'd1;
   localparam logic [2:0] CSR_CAM_Y   = 3'd2;
   localparam logic [2:0] CSR_CAM_Z   = 3'd3;
   localparam logic [2:0] CSR_BOUNCES = 3'd4;
   localparam logic [2:0] CSR_SPHERES = 3'd5;

   typedef logic signed [67:0] wide_type;

   function automatic logic signed [31:0] sat32(input wide_type v);
      if (v > 68'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic wide_type sx32(input logic signed [31:0] x);
      return {{36{x[31]}}, x};
   endfunction

endpackage

`default_nettype wire

// ===== src/srt_isqrt.sv =====
`default_nettype none

module srt_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] val,
   output logic             done,
   output logic [31:0]      root
);
   import srt_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] val_ff, val_in;
   logic [35:0] remsh;
   logic [35:0] trial;

   assign remsh = {rem_ff[33:0], val_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      val_in  = val_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = '0;
         root_in = '0;
         val_in  = val;
      end else if (busy_ff) begin
         val_in = {val_ff[61:0], 2'b00};
         if (remsh >= trial) begin
            rem_in  = remsh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = remsh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      val_ff  <= val_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ===== src/srt_div.sv =====
`default_nettype none

module srt_div #(
   parameter int NUM_W = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [31:0]      den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   import srt_pkg::*;

   localparam int CW = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [32:0]      remsh;
   logic             ge;

   assign remsh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = remsh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W - 1);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(remsh - {1'b0, den_ff}) : remsh[31:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ===== src/sphere_reflection_ray_tracer.sv =====
// a sphere write completes in idle; a trace runs passes, where a pass is one
//   nearest-sphere search, and each hit also takes a normalize, which uses the
//   square root unit and the divider
// throughput: one beat at a time, set by the shared multiplier, the 32-step
//   square root unit and the (32 + FRAC_BITS)-step divider
// reset: control clears, registers take their defaults, the sphere table reads zero
`default_nettype none

module sphere_reflection_ray_tracer #(
   parameter int MAX_SPHERES = srt_pkg::MAX_SPHERES_DEF,
   parameter int FRAC_BITS   = srt_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [2:0]         req_sphere_slot,
   input  wire logic [3:0]         req_attribute,
   input  wire logic signed [31:0] req_attribute_value,
   input  wire logic signed [19:0] req_screen_x,
   input  wire logic signed [19:0] req_screen_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import srt_pkg::*;

   localparam int SLOT_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int AW     = SLOT_W + 4;
   localparam int DEPTH  = 2 ** AW;
   localparam int NUM_W  = 32 + FRAC_BITS;
   localparam logic signed [31:0] ONE_Q    = 32'(64'd1 << FRAC_BITS);
   localparam logic signed [31:0] POINT3_Q = 32'((3 * (64'd1 << FRAC_BITS) + 5) / 10);

   typedef enum logic [33:0] {
      ST_IDLE   = 34'h000000001,
      ST_VX     = 34'h000000002,
      ST_VY     = 34'h000000004,
      ST_VZ     = 34'h000000008,
      ST_DOT    = 34'h000000010,
      ST_NSQRT  = 34'h000000020,
      ST_NLEN   = 34'h000000040,
      ST_NDIV   = 34'h000000080,
      ST_NDIVW  = 34'h000000100,
      ST_SETDIR = 34'h000000200,
      ST_BSTART = 34'h000000400,
      ST_SLOOP  = 34'h000000800,
      ST_HRD    = 34'h000001000,
      ST_HLCOS  = 34'h000002000,
      ST_HLSQ   = 34'h000004000,
      ST_HLLEN  = 34'h000008000,
      ST_HLC2   = 34'h000010000,
      ST_HR2    = 34'h000020000,
      ST_HCMP   = 34'h000040000,
      ST_HSQ2   = 34'h000080000,
      ST_HPOS   = 34'h000100000,
      ST_HDD    = 34'h000200000,
      ST_HD2    = 34'h000400000,
      ST_SNEXT  = 34'h000800000,
      ST_BEND   = 34'h001000000,
      ST_NRD    = 34'h002000000,
      ST_FLIP   = 34'h004000000,
      ST_FLIP2  = 34'h008000000,
      ST_CRD    = 34'h010000000,
      ST_CSUM   = 34'h020000000,
      ST_CWGT   = 34'h040000000,
      ST_RFD    = 34'h080000000,
      ST_RMUL   = 34'h100000000,
      ST_FIN    = 34'h200000000
   } state_type;

   state_type state_ff, state_in, dret_ff, dret_in, nret_ff, nret_in;
   logic [2:0]  k_ff, k_in;
   logic        dbdir_ff, dbdir_in;

   logic [30:0]        vf_ff, vf_in;
   logic signed [31:0] cam_ff [3];
   logic signed [31:0] cam_in [3];
   logic [3:0]         mb_ff, mb_in, siu_ff, siu_in;

   logic signed [31:0] org_ff [3], org_in [3];
   logic signed [31:0] dir_ff [3], dir_in [3];
   logic signed [31:0] vec_ff [3], vec_in [3];
   logic signed [31:0] sum_ff [3], sum_in [3];
   logic signed [31:0] wgt_ff [3], wgt_in [3];
   logic signed [31:0] colt_ff [3], colt_in [3];
   logic signed [31:0] sur_ff [3], sur_in [3];
   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [31:0] bpos_ff [3], bpos_in [3];
   logic signed [31:0] r_ff, r_in;
   logic signed [19:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [3:0]         bl_ff, bl_in, n_ff, n_in, scnt_ff, scnt_in, best_ff, best_in;
   logic               have_ff, have_in;
   logic [63:0]        bestd_ff, bestd_in, acc_ff, acc_in;
   logic [63:0]        lsq_ff, lsq_in, lsin_ff, lsin_in;
   logic signed [63:0] lcos_ff, lcos_in;
   logic signed [32:0] dist_ff, dist_in, fd_ff, fd_in;
   logic [31:0]        len_ff, len_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [7:0]         red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        sph_mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff, vld_in;
   logic [31:0]        rdata_ff;
   logic               rvld_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   logic signed [31:0] rv;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] sh;
   wide_type           sh68;
   logic signed [63:0] dsh;
   logic [1:0]         ki;
   logic [2:0]         km1, sidx;

   logic               sq_start, sq_done;
   logic [63:0]        sq_val;
   logic [31:0]        sq_root;
   logic               dv_start, dv_done;
   logic [NUM_W-1:0]   dv_num, dv_quo;
   logic [31:0]        vabs;
   logic [7:0]         chan [3];

   srt_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .val   (sq_val),
      .done  (sq_done),
      .root  (sq_root)
   );

   srt_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (len_ff),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   assign ki   = (k_ff[1:0] == 2'd3) ? 2'd0 : k_ff[1:0];
   assign km1  = k_ff - 3'd1;
   assign sidx = km1 - 3'd3;
   assign sh   = prod_ff >>> FRAC_BITS;
   assign sh68 = {{2{sh[65]}}, sh};
   assign dsh  = $signed(acc_ff) >>> FRAC_BITS;
   assign rv   = rvld_ff ? $signed(rdata_ff) : 32'sd0;
   assign vabs = vec_ff[ki][31] ? 32'(-vec_ff[ki]) : vec_ff[ki];
   assign dv_num = {vabs, {FRAC_BITS{1'b0}}};

   assign wr_en   = req_valid && req_ready && (req_command == CMD_WRITE)
                    && (32'(req_sphere_slot) < MAX_SPHERES) && (req_attribute <= ATTR_LAST);
   assign wr_addr = {SLOT_W'(req_sphere_slot), req_attribute};

   // table read address
   always_comb begin
      case (state_ff)
         ST_HRD:  rd_addr = {SLOT_W'(scnt_ff), ATTR_CX + {1'b0, k_ff}};
         ST_NRD:  rd_addr = {SLOT_W'(best_ff), ATTR_CX + {1'b0, k_ff}};
         ST_CRD:  rd_addr = (k_ff < 3'd3) ? {SLOT_W'(best_ff), ATTR_ER + {1'b0, k_ff}}
                                          : {SLOT_W'(best_ff), ATTR_SR + {1'b0, sidx + 3'd1}};
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sph_mem[wr_addr] <= req_attribute_value;
      end
      rdata_ff <= sph_mem[rd_addr];
      rvld_ff  <= vld_ff[rd_addr];
   end

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_VX: begin
            mul_a = 33'(sx_ff);
            mul_b = {2'b00, vf_ff};
         end
         ST_VY: begin
            mul_a = 33'(sy_ff);
            mul_b = {2'b00, vf_ff};
         end
         ST_DOT: begin
            mul_a = 33'(vec_ff[ki]);
            mul_b = dbdir_ff ? 33'(dir_ff[ki]) : 33'(vec_ff[ki]);
         end
         ST_HLC2: begin
            mul_a = lcos_ff[32:0];
            mul_b = lcos_ff[32:0];
         end
         ST_HR2: begin
            mul_a = 33'(r_ff);
            mul_b = 33'(r_ff);
         end
         ST_HPOS: begin
            mul_a = 33'(dir_ff[ki]);
            mul_b = dist_ff;
         end
         ST_CSUM: begin
            mul_a = 33'(wgt_ff[ki]);
            mul_b = 33'(colt_ff[ki]);
         end
         ST_CWGT: begin
            mul_a = 33'(wgt_ff[ki]);
            mul_b = 33'(sur_ff[ki]);
         end
         ST_RMUL: begin
            mul_a = 33'(vec_ff[ki]);
            mul_b = fd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // output channels
   always_comb begin
      logic signed [31:0] c;
      logic [39:0]        c40;
      for (int i = 0; i < 3; i++) begin
         c = sum_ff[i];
         if (c[31]) begin
            c = '0;
         end else if (c > ONE_Q) begin
            c = ONE_Q;
         end
         c40 = {8'd0, c};
         chan[i] = 8'(((c40 << 8) - c40) >> FRAC_BITS);
      end
   end

   always_comb begin
      state_in = state_ff;
      dret_in  = dret_ff;
      nret_in  = nret_ff;
      k_in     = k_ff;
      dbdir_in = dbdir_ff;
      vf_in    = vf_ff;
      cam_in   = cam_ff;
      mb_in    = mb_ff;
      siu_in   = siu_ff;
      org_in   = org_ff;
      dir_in   = dir_ff;
      vec_in   = vec_ff;
      sum_in   = sum_ff;
      wgt_in   = wgt_ff;
      colt_in  = colt_ff;
      sur_in   = sur_ff;
      pos_in   = pos_ff;
      bpos_in  = bpos_ff;
      r_in     = r_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      bl_in    = bl_ff;
      n_in     = n_ff;
      scnt_in  = scnt_ff;
      best_in  = best_ff;
      have_in  = have_ff;
      bestd_in = bestd_ff;
      acc_in   = acc_ff;
      lsq_in   = lsq_ff;
      lsin_in  = lsin_ff;
      lcos_in  = lcos_ff;
      dist_in  = dist_ff;
      fd_in    = fd_ff;
      len_in   = len_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sq_start = 1'b0;
      sq_val   = acc_ff;
      dv_start = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_VIEW:    vf_in     = csr_data[30:0];
            CSR_CAM_X:   cam_in[0] = $signed(csr_data);
            CSR_CAM_Y:   cam_in[1] = $signed(csr_data);
            CSR_CAM_Z:   cam_in[2] = $signed(csr_data);
            CSR_BOUNCES: mb_in     = csr_data[3:0];
            CSR_SPHERES: siu_in    = csr_data[3:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_command == CMD_TRACE) begin
               sx_in   = req_screen_x;
               sy_in   = req_screen_y;
               org_in  = cam_ff;
               bl_in   = mb_ff;
               scnt_in = '0;
               n_in    = (32'(siu_ff) > MAX_SPHERES) ? 4'(MAX_SPHERES) : siu_ff;
               for (int i = 0; i < 3; i++) begin
                  sum_in[i] = '0;
                  wgt_in[i] = ONE_Q;
               end
               state_in = ST_VX;
            end
         end
         ST_VX: state_in = ST_VY;
         ST_VY: begin
            vec_in[0] = sat32(sh68);
            state_in  = ST_VZ;
         end
         ST_VZ: begin
            vec_in[1] = sat32(sh68);
            vec_in[2] = -ONE_Q;
            acc_in    = '0;
            k_in      = '0;
            dbdir_in  = 1'b0;
            dret_in   = ST_NSQRT;
            nret_in   = ST_SETDIR;
            state_in  = ST_DOT;
         end
         ST_DOT: begin
            if (k_ff != 3'd0) begin
               acc_in = acc_ff + prod_ff[63:0];
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               state_in = dret_ff;
            end
         end
         ST_NSQRT: begin
            sq_start = 1'b1;
            state_in = ST_NLEN;
         end
         ST_NLEN: begin
            if (sq_done) begin
               len_in   = sq_root;
               k_in     = '0;
               state_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            if (k_ff == 3'd3) begin
               state_in = nret_ff;
            end else if (len_ff == '0) begin
               vec_in[ki] = '0;
               k_in       = k_ff + 3'd1;
            end else begin
               dv_start = 1'b1;
               state_in = ST_NDIVW;
            end
         end
         ST_NDIVW: begin
            if (dv_done) begin
               if (vec_ff[ki][31]) begin
                  vec_in[ki] = (dv_quo > (NUM_W'(1) << 31)) ? 32'sh80000000
                                                            : 32'(-dv_quo);
               end else begin
                  vec_in[ki] = (dv_quo > ((NUM_W'(1) << 31) - NUM_W'(1))) ? 32'sh7fffffff
                                                                          : dv_quo[31:0];
               end
               k_in     = k_ff + 3'd1;
               state_in = ST_NDIV;
            end
         end
         ST_SETDIR: begin
            dir_in   = vec_ff;
            state_in = ST_BSTART;
         end
         ST_BSTART: begin
            have_in  = 1'b0;
            scnt_in  = '0;
            state_in = ST_SLOOP;
         end
         ST_SLOOP: begin
            k_in     = '0;
            state_in = (scnt_ff == n_ff) ? ST_BEND : ST_HRD;
         end
         ST_HRD: begin
            if (k_ff != 3'd0) begin
               if (km1 < 3'd3) begin
                  vec_in[km1[1:0]] = sat32(sx32(rv) - sx32(org_ff[km1[1:0]]));
               end else begin
                  r_in = rv;
               end
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               acc_in   = '0;
               k_in     = '0;
               dbdir_in = 1'b1;
               dret_in  = ST_HLCOS;
               state_in = ST_DOT;
            end
         end
         ST_HLCOS: begin
            if (dsh <= 64'sd0) begin
               state_in = ST_SNEXT;
            end else begin
               lcos_in  = dsh;
               acc_in   = '0;
               k_in     = '0;
               dbdir_in = 1'b0;
               dret_in  = ST_HLSQ;
               state_in = ST_DOT;
            end
         end
         ST_HLSQ: begin
            lsq_in   = acc_ff;
            sq_start = 1'b1;
            state_in = ST_HLLEN;
         end
         ST_HLLEN: begin
            if (sq_done) begin
               if (lcos_ff > $signed({32'd0, sq_root})) begin
                  lcos_in = $signed({32'd0, sq_root});
               end
               state_in = ST_HLC2;
            end
         end
         ST_HLC2: state_in = ST_HR2;
         ST_HR2: begin
            lsin_in  = lsq_ff - prod_ff[63:0];
            state_in = ST_HCMP;
         end
         ST_HCMP: begin
            if (lsin_ff > prod_ff[63:0]) begin
               state_in = ST_SNEXT;
            end else begin
               sq_start = 1'b1;
               sq_val   = prod_ff[63:0] - lsin_ff;
               state_in = ST_HSQ2;
            end
         end
         ST_HSQ2: begin
            if (sq_done) begin
               dist_in  = $signed({1'b0, lcos_ff[31:0]}) - $signed({1'b0, sq_root});
               k_in     = '0;
               state_in = ST_HPOS;
            end
         end
         ST_HPOS: begin
            if (k_ff != 3'd0) begin
               pos_in[km1[1:0]] = sat32(sx32(org_ff[km1[1:0]]) + sh68);
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               state_in = ST_HDD;
            end
         end
         ST_HDD: begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = sat32(sx32(pos_ff[i]) - sx32(org_ff[i]));
            end
            acc_in   = '0;
            k_in     = '0;
            dbdir_in = 1'b0;
            dret_in  = ST_HD2;
            state_in = ST_DOT;
         end
         ST_HD2: begin
            if (!have_ff || acc_ff < bestd_ff) begin
               have_in  = 1'b1;
               best_in  = scnt_ff;
               bestd_in = acc_ff;
               bpos_in  = pos_ff;
            end
            state_in = ST_SNEXT;
         end
         ST_SNEXT: begin
            scnt_in  = scnt_ff + 4'd1;
            state_in = ST_SLOOP;
         end
         ST_BEND: begin
            k_in     = '0;
            state_in = have_ff ? ST_NRD : ST_FIN;
         end
         ST_NRD: begin
            if (k_ff != 3'd0) begin
               vec_in[km1[1:0]] = sat32(sx32(bpos_ff[km1[1:0]]) - sx32(rv));
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               acc_in   = '0;
               k_in     = '0;
               dbdir_in = 1'b0;
               dret_in  = ST_NSQRT;
               nret_in  = ST_FLIP;
               state_in = ST_DOT;
            end
         end
         ST_FLIP: begin
            acc_in   = '0;
            k_in     = '0;
            dbdir_in = 1'b1;
            dret_in  = ST_FLIP2;
            state_in = ST_DOT;
         end
         ST_FLIP2: begin
            if (dsh > 64'sd0) begin
               for (int i = 0; i < 3; i++) begin
                  vec_in[i] = -vec_ff[i];
               end
            end
            k_in     = '0;
            state_in = ST_CRD;
         end
         ST_CRD: begin
            if (k_ff != 3'd0) begin
               if (km1 < 3'd3) begin
                  colt_in[km1[1:0]] = (bl_ff == '0) ? rv
                                                    : sat32(sx32(POINT3_Q) + sx32(rv));
               end else begin
                  sur_in[sidx[1:0]] = rv;
               end
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd6) begin
               k_in     = '0;
               state_in = ST_CSUM;
            end
         end
         ST_CSUM: begin
            if (k_ff != 3'd0) begin
               sum_in[km1[1:0]] = sat32(sx32(sum_ff[km1[1:0]]) + sx32(sat32(sh68)));
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               k_in     = '0;
               state_in = (bl_ff == '0) ? ST_FIN : ST_CWGT;
            end
         end
         ST_CWGT: begin
            if (k_ff != 3'd0) begin
               wgt_in[km1[1:0]] = sat32(sh68);
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               acc_in   = '0;
               k_in     = '0;
               dbdir_in = 1'b1;
               dret_in  = ST_RFD;
               state_in = ST_DOT;
            end
         end
         ST_RFD: begin
            fd_in    = dsh[32:0];
            k_in     = '0;
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            if (k_ff != 3'd0) begin
               dir_in[km1[1:0]] = sat32(sx32(dir_ff[km1[1:0]]) - (sh68 <<< 1));
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               org_in   = bpos_ff;
               bl_in    = bl_ff - 4'd1;
               state_in = ST_BSTART;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               red_in       = chan[0];
               green_in     = chan[1];
               blue_in      = chan[2];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dret_ff      <= ST_IDLE;
         nret_ff      <= ST_IDLE;
         k_ff         <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         vf_ff        <= VIEW_FACTOR_RST;
         cam_ff       <= '{default: '0};
         mb_ff        <= MAX_BOUNCES_RST;
         siu_ff       <= '0;
         bl_ff        <= '0;
         scnt_ff      <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         dret_ff      <= dret_in;
         nret_ff      <= nret_in;
         k_ff         <= k_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         vf_ff        <= vf_in;
         cam_ff       <= cam_in;
         mb_ff        <= mb_in;
         siu_ff       <= siu_in;
         bl_ff        <= bl_in;
         scnt_ff      <= scnt_in;
         n_ff         <= n_in;
      end
      dbdir_ff <= dbdir_in;
      org_ff   <= org_in;
      dir_ff   <= dir_in;
      vec_ff   <= vec_in;
      sum_ff   <= sum_in;
      wgt_ff   <= wgt_in;
      colt_ff  <= colt_in;
      sur_ff   <= sur_in;
      pos_ff   <= pos_in;
      bpos_ff  <= bpos_in;
      r_ff     <= r_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      acc_ff   <= acc_in;
      lsq_ff   <= lsq_in;
      lsin_ff  <= lsin_in;
      lcos_ff  <= lcos_in;
      dist_ff  <= dist_in;
      fd_ff    <= fd_in;
      len_ff   <= len_in;
      prod_ff  <= prod_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result beat raised outside finish");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_WRITE) |=> state_ff == ST_IDLE)
      else $error("write beat left idle");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished trace lost its result");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> scnt_ff <= n_ff)
      else $error("sphere counter beyond count");

endmodule

`default_nettype wire

// ===== tb/srt_checker.sv =====
module srt_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_command,
   input  wire logic [2:0]         req_sphere_slot,
   input  wire logic [3:0]         req_attribute,
   input  wire logic signed [31:0] req_attribute_value,
   input  wire logic signed [19:0] req_screen_x,
   input  wire logic signed [19:0] req_screen_y,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [7:0]         rsp_red,
   input  wire logic [7:0]         rsp_green,
   input  wire logic [7:0]         rsp_blue,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output int                      fail_count,
   output int                      pending
);
   import srt_pkg::*;

   typedef logic signed [79:0] num_type;
   typedef num_type vec3_type [3];

   localparam num_type ONE    = 80'sd65536;
   localparam num_type POINT3 = 80'sd19661;

   num_type center [24];
   num_type radius [8];
   num_type surface [24];
   num_type emission [24];
   num_type view_factor;
   num_type camera [3];
   int unsigned bounce_limit;
   int unsigned spheres_used;
   logic [23:0] pixel_q [$];

   function automatic num_type sat(input num_type v);
      if (v > 80'sd2147483647) return 80'sd2147483647;
      if (v < -80'sd2147483648) return -80'sd2147483648;
      return v;
   endfunction

   function automatic num_type fsh(input num_type v);
      return v >>> 16;
   endfunction

   function automatic num_type qmul(input num_type a, input num_type b);
      return sat(fsh(a * b));
   endfunction

   function automatic num_type root(input num_type v);
      num_type r, t;
      r = 0;
      for (int b = 36; b >= 0; b--) begin
         t = r + (num_type'(1) <<< b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic num_type sqlen(input vec3_type c);
      return c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
   endfunction

   function automatic num_type qdot(input vec3_type a, input vec3_type b);
      return fsh(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
   endfunction

   task automatic unit_vec(input vec3_type c, output vec3_type o);
      num_type len;
      len = root(sqlen(c));
      for (int k = 0; k < 3; k++) o[k] = (len == 0) ? 0 : sat((c[k] <<< 16) / len);
   endtask

   task automatic probe_sphere(input int s, input vec3_type org, input vec3_type dir,
                               output bit hit, output vec3_type pos, output vec3_type nrm);
      vec3_type l, d;
      num_type lcos, lsq, llen, lsin, r2, hit_dist;
      hit = 0;
      for (int k = 0; k < 3; k++) l[k] = sat(center[s * 3 + k] - org[k]);
      lcos = qdot(l, dir);
      if (lcos <= 0) return;
      lsq = sqlen(l);
      llen = root(lsq);
      if (lcos > llen) lcos = llen;
      lsin = lsq - lcos * lcos;
      r2 = radius[s] * radius[s];
      if (lsin > r2) return;
      hit_dist = lcos - root(r2 - lsin);
      for (int k = 0; k < 3; k++) pos[k] = sat(org[k] + fsh(dir[k] * hit_dist));
      for (int k = 0; k < 3; k++) d[k] = sat(pos[k] - center[s * 3 + k]);
      unit_vec(d, nrm);
      hit = 1;
   endtask

   task automatic shade_ray(input num_type sx, input num_type sy, output logic [23:0] rgb);
      vec3_type org, dir, v, sum, wt, p, q, dd, bpos, bnrm;
      num_type d2, best_d, fd, t, c;
      int best, n;
      int unsigned left;
      bit hit, done;
      org = camera;
      v[0] = qmul(sx, view_factor);
      v[1] = qmul(sy, view_factor);
      v[2] = -ONE;
      unit_vec(v, dir);
      for (int k = 0; k < 3; k++) begin
         sum[k] = 0;
         wt[k] = ONE;
      end
      left = bounce_limit;
      n = (spheres_used > 8) ? 8 : spheres_used;
      done = 0;
      while (!done) begin
         best = -1;
         best_d = 0;
         for (int s = 0; s < n; s++) begin
            probe_sphere(s, org, dir, hit, p, q);
            if (hit) begin
               for (int k = 0; k < 3; k++) dd[k] = sat(p[k] - org[k]);
               d2 = sqlen(dd);
               if (best < 0 || d2 < best_d) begin
                  best = s;
                  best_d = d2;
                  bpos = p;
                  bnrm = q;
               end
            end
         end
         if (best < 0) begin
            done = 1;
         end else begin
            if (qdot(dir, bnrm) > 0)
               for (int k = 0; k < 3; k++) bnrm[k] = -bnrm[k];
            if (left == 0) begin
               for (int k = 0; k < 3; k++)
                  sum[k] = sat(sum[k] + qmul(wt[k], emission[best * 3 + k]));
               done = 1;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  t = sat(POINT3 + emission[best * 3 + k]);
                  sum[k] = sat(sum[k] + qmul(wt[k], t));
                  wt[k] = qmul(wt[k], surface[best * 3 + k]);
               end
               fd = qdot(dir, bnrm);
               for (int k = 0; k < 3; k++) begin
                  dir[k] = sat(dir[k] - 2 * fsh(bnrm[k] * fd));
                  org[k] = bpos[k];
               end
               left--;
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         c = sum[k];
         if (c < 0) c = 0;
         if (c > ONE) c = ONE;
         c = fsh(c * 255);
         rgb[23 - 8 * k -: 8] = c[7:0];
      end
   endtask

   always @(posedge clock) begin
      logic [23:0] rgb;
      logic [23:0] want;
      int a;
      if (reset) begin
         for (int k = 0; k < 24; k++) begin
            center[k] = 0;
            surface[k] = 0;
            emission[k] = 0;
         end
         for (int k = 0; k < 8; k++) radius[k] = 0;
         for (int k = 0; k < 3; k++) camera[k] = 0;
         view_factor = num_type'(VIEW_FACTOR_RST);
         bounce_limit = MAX_BOUNCES_RST;
         spheres_used = 0;
         pixel_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VIEW:    view_factor = num_type'({1'b0, csr_data[30:0]});
               CSR_CAM_X:   camera[0] = num_type'($signed(csr_data));
               CSR_CAM_Y:   camera[1] = num_type'($signed(csr_data));
               CSR_CAM_Z:   camera[2] = num_type'($signed(csr_data));
               CSR_BOUNCES: bounce_limit = csr_data[3:0];
               CSR_SPHERES: spheres_used = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_TRACE) begin
               shade_ray(num_type'(req_screen_x), num_type'(req_screen_y), rgb);
               pixel_q.insert(pixel_q.size(), rgb);
            end else begin
               a = req_attribute;
               if (a < ATTR_RAD)
                  center[req_sphere_slot * 3 + a] = num_type'(req_attribute_value);
               else if (a == ATTR_RAD)
                  radius[req_sphere_slot] = num_type'(req_attribute_value);
               else if (a < ATTR_ER)
                  surface[req_sphere_slot * 3 + a - ATTR_SR] = num_type'(req_attribute_value);
               else if (a <= ATTR_LAST)
                  emission[req_sphere_slot * 3 + a - ATTR_ER] = num_type'(req_attribute_value);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("pixel beat with no trace outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_red !== want[23:16])
                  $error("red expected %0d actual %0d", want[23:16], rsp_red);
               if (rsp_green !== want[15:8])
                  $error("green expected %0d actual %0d", want[15:8], rsp_green);
               if (rsp_blue !== want[7:0])
                  $error("blue expected %0d actual %0d", want[7:0], rsp_blue);
               if ({rsp_red, rsp_green, rsp_blue} !== want) fail_count <= fail_count + 1;
            end
         end
      end
      pending <= pixel_q.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import srt_pkg::*;

   localparam int LIMIT = 12000000;

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready, req_command;
   logic [2:0]         req_sphere_slot;
   logic [3:0]         req_attribute;
   logic signed [31:0] req_attribute_value;
   logic signed [19:0] req_screen_x, req_screen_y;
   logic               rsp_valid, rsp_ready;
   logic [7:0]         rsp_red, rsp_green, rsp_blue;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   int                 fail_count, pending;
   int                 snd_idle, rcv_idle;
   int                 hold_asks, hold_seen, hold_left;
   int                 cycles, traces, writes;

   sphere_reflection_ray_tracer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_sphere_slot(req_sphere_slot), .req_attribute(req_attribute),
      .req_attribute_value(req_attribute_value),
      .req_screen_x(req_screen_x), .req_screen_y(req_screen_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   srt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_sphere_slot(req_sphere_slot), .req_attribute(req_attribute),
      .req_attribute_value(req_attribute_value),
      .req_screen_x(req_screen_x), .req_screen_y(req_screen_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .fail_count(fail_count), .pending(pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("sphere_reflection_ray_tracer regression: fail");
         $finish;
      end
   end

   // receiver, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 15000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   task automatic send(input logic cmd, input logic [2:0] slot, input logic [3:0] attr,
                       input logic [31:0] val, input int sx, input int sy);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < snd_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sphere_slot <= slot;
      req_attribute <= attr;
      req_attribute_value <= val;
      req_screen_x <= sx[19:0];
      req_screen_y <= sy[19:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_TRACE) traces++;
      else writes++;
   endtask

   task automatic put(input int slot, input int attr, input int val);
      send(CMD_WRITE, slot[2:0], 4'(attr), val, $urandom_range(524287),
           $urandom_range(524287));
   endtask

   task automatic trace(input int sx, input int sy);
      send(CMD_TRACE, 3'($urandom), 4'($urandom), $urandom, sx, sy);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic rand_setup;
      csr_write(CSR_VIEW, {1'($urandom_range(1)), 31'($urandom_range(70000, 8000))});
      csr_write(CSR_CAM_X, $urandom_range(131072) - 65536);
      csr_write(CSR_CAM_Y, $urandom_range(131072) - 65536);
      csr_write(CSR_CAM_Z, $urandom_range(131072) - 65536);
      csr_write(CSR_BOUNCES, {28'($urandom), 4'($urandom_range(6))});
      csr_write(CSR_SPHERES, {28'($urandom), 4'($urandom_range(15, 2))});
   endtask

   task automatic rand_item;
      int a, v;
      if ($urandom_range(99) < 40) begin
         trace($urandom_range(524288) - 262144, $urandom_range(524288) - 262144);
      end else begin
         a = ($urandom_range(9) == 0) ? $urandom_range(15, 10) : $urandom_range(9);
         if ($urandom_range(9) == 0) v = $urandom;
         else if (a < 2) v = $urandom_range(524288) - 262144;
         else if (a == 2) v = -$urandom_range(786432, 131072);
         else if (a == 3) v = $urandom_range(196608, 19661);
         else v = $urandom_range(80000);
         put($urandom_range(7), a, v);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_sphere_slot = '0;
      req_attribute = '0;
      req_attribute_value = '0;
      req_screen_x = '0;
      req_screen_y = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      snd_idle = 0;
      rcv_idle = 0;
      hold_asks = 0;
      hold_seen = 0;
      hold_left = 0;
      cycles = 0;
      traces = 0;
      writes = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty scene at reset config, then a small reflective scene
      trace(0, 0);
      put(0, ATTR_CX + 2, -5 * 65536);
      put(0, ATTR_RAD, 65536);
      put(0, ATTR_SR, 32768);
      put(0, ATTR_SR + 1, 65536);
      put(0, ATTR_ER, 13107);
      put(1, ATTR_CX + 2, -5 * 65536);
      put(1, ATTR_RAD, -65536);
      put(2, ATTR_CX, 2 * 65536);
      put(2, ATTR_CX + 2, -4 * 65536);
      put(2, ATTR_RAD, 98304);
      put(2, ATTR_ER + 2, 2 * 65536);
      put(3, 4'd12, 32'h7fffffff);
      put(3, 4'd15, 32'h80000000);
      drain;
      csr_write(CSR_SPHERES, 3);
      trace(0, 0);
      trace(262144, 262144);
      trace(-262144, -262144);
      trace(20000, 0);
      drain;
      csr_write(CSR_BOUNCES, 0);
      trace(0, 0);
      put(4, ATTR_RAD, 32'h80000000);
      put(5, ATTR_ER + 1, 32'h7fffffff);
      drain;
      csr_write(CSR_BOUNCES, 15);
      csr_write(CSR_SPHERES, 15);
      csr_write(CSR_VIEW, 32'hffffffff);
      trace(262144, -262144);
      trace(0, 0);
      drain;
      csr_write(CSR_VIEW, 0);
      csr_write(CSR_CAM_X, 32'h7fffffff);
      csr_write(CSR_CAM_Y, 32'h80000000);
      csr_write(CSR_CAM_Z, 32'h7fffffff);
      trace(100000, 100000);
      drain;
      csr_write(CSR_SPHERES, 8);
      csr_write(CSR_CAM_X, 32'h80000000);
      csr_write(CSR_CAM_Y, 32'h7fffffff);
      csr_write(CSR_CAM_Z, 32'h80000000);
      trace(-100000, 0);
      drain;

      for (int ph = 0; ph < 3; ph++) begin
         snd_idle = (ph == 0) ? 27 : (ph == 1) ? 57 : 0;
         rcv_idle = (ph == 0) ? 57 : (ph == 1) ? 27 : 0;
         drain;
         rand_setup;
         for (int i = 0; i < 100; i++) begin
            if (ph == 1 && i == 40) hold_asks = hold_asks + 1;
            rand_item;
         end
      end
      drain;

      $display("covered %0d sphere writes and %0d traces over three idle mixes,", writes,
               traces);
      $display("with extreme camera, view, bounce and sphere-count settings");
      if (fail_count == 0) begin
         $display("sphere_reflection_ray_tracer regression: pass");
      end else begin
         $display("sphere_reflection_ray_tracer regression: fail");
      end
      $finish;
   end

endmodule

// ===== sphere_reflection_ray_tracer.f =====
src/srt_pkg.sv
src/srt_isqrt.sv
src/srt_div.sv
src/sphere_reflection_ray_tracer.sv
tb/srt_checker.sv
tb/tb.sv
